>>> hw/rtl/esc_pkg.sv
// shared types, constants and helpers for the environmental sensor compensation block
// used by the top level and esc_engine; depends on nothing
package esc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_COEFFS  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LOW    = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HIGH   = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_NINE   = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM_COEFFS   = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_HIGH    = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_LOW     = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_HUM_HIGH     = 4'd7;

  // reset values of the limits
  localparam logic [15:0] TEMP_HIGH_RST = 16'd4000;
  localparam logic [15:0] TEMP_LOW_RST  = 16'd0;
  localparam logic [16:0] HUM_HIGH_RST  = 17'd81920;

  // saturation bounds
  localparam logic signed [63:0] QUOT_GUARD = 64'sd67108864;     // 2^26
  localparam logic signed [63:0] QUOT_LIMIT = 64'sd68719476736;  // 2^36
  localparam logic signed [63:0] HV_LIMIT   = 64'sd17592186044416; // 2^44
  localparam logic signed [63:0] HUM_MAX    = 64'sd419430400;
  localparam logic signed [63:0] PRESS_MAX  = 64'sd33554431;
  localparam logic signed [63:0] D_BIAS     = 64'sd140737488355328; // 2^47

  // raw reading word
  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } raw_t;

  // compensated result word
  typedef struct packed {
    logic [15:0] temperature;
    logic [24:0] pressure;
    logic [16:0] humidity;
    logic        temp_alarm;
    logic        humidity_alarm;
  } res_t;

  // calibration and limit registers
  typedef struct packed {
    logic [47:0] temp_coeffs;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_nine;
    logic [63:0] hum_coeffs;
    logic [15:0] temp_high;
    logic [15:0] temp_low;
    logic [16:0] hum_high;
  } cfg_t;

  // sequencer steps of the compensation engine
  typedef enum logic [4:0] {
    S_IDLE, S_TA, S_TB, S_TC, S_TEMP,
    S_SQ, S_P6, S_P5, S_P3, S_P2, S_P1H, S_P1L, S_PCHK,
    S_DQ, S_QCHK, S_R, S_Q, S_DR, S_SS, S_P9, S_P8, S_PRES,
    S_H5, S_H6, S_H3, S_HXY, S_H2, S_HAB, S_HCHK, S_HS, S_H1,
    S_DONE
  } state_e;

  function automatic logic signed [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] sext12(input logic [11:0] v);
    return {{52{v[11]}}, v};
  endfunction

  function automatic logic signed [63:0] sext8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

endpackage

>>> hw/rtl/env_sensor_compensation.sv
// top level of the environmental sensor compensation block
// depends on esc_pkg, esc_fifo and esc_engine
//
// Takes raw pressure, temperature and humidity readings through a push/full
// queue and returns compensated temperature (0.01 degC), pressure (1/256 Pa)
// and humidity (1/1024 %RH) with two limit alarms through an empty/pop queue.
// The input queue accepts words while the engine works. The engine pops a
// word only when idle, so it takes the next one after pushing the last result.
// It skips the last humidity steps when the humidity product is zero or
// below, both pressure divisions when the pressure divisor is zero and the
// second when the quotient saturates. Its pace is set by the single shared
// multiplier (one 16-bit digit a cycle, up to 23 products) and the
// one-bit-a-cycle divider. A finished word waits in the engine while the
// result queue is full. The user must write calibration registers through
// cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not enforce it.
module env_sensor_compensation #(
  parameter int unsigned IN_DEPTH  = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [19:0] raw_pressure_i,
  input  logic [19:0] raw_temperature_i,
  input  logic [15:0] raw_humidity_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] temperature_o,
  output logic [24:0] pressure_o,
  output logic [16:0] humidity_o,
  output logic        temp_alarm_o,
  output logic        humidity_alarm_o,
  input  logic        cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  esc_pkg::cfg_t cfg_q;
  esc_pkg::raw_t in_word, eng_word;
  esc_pkg::res_t res_word, head_word;
  logic          eng_valid_n, eng_pop, res_full, res_push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_coeffs <= '0;
      cfg_q.press_low   <= '0;
      cfg_q.press_high  <= '0;
      cfg_q.press_nine  <= '0;
      cfg_q.hum_coeffs  <= '0;
      cfg_q.temp_high   <= esc_pkg::TEMP_HIGH_RST;
      cfg_q.temp_low    <= esc_pkg::TEMP_LOW_RST;
      cfg_q.hum_high    <= esc_pkg::HUM_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        esc_pkg::CFG_TEMP_COEFFS: cfg_q.temp_coeffs <= cfg_data_i[47:0];
        esc_pkg::CFG_PRESS_LOW:   cfg_q.press_low   <= cfg_data_i;
        esc_pkg::CFG_PRESS_HIGH:  cfg_q.press_high  <= cfg_data_i;
        esc_pkg::CFG_PRESS_NINE:  cfg_q.press_nine  <= cfg_data_i[15:0];
        esc_pkg::CFG_HUM_COEFFS:  cfg_q.hum_coeffs  <= cfg_data_i;
        esc_pkg::CFG_TEMP_HIGH:   cfg_q.temp_high   <= cfg_data_i[15:0];
        esc_pkg::CFG_TEMP_LOW:    cfg_q.temp_low    <= cfg_data_i[15:0];
        esc_pkg::CFG_HUM_HIGH:    cfg_q.hum_high    <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign in_word.raw_pressure    = raw_pressure_i;
  assign in_word.raw_temperature = raw_temperature_i;
  assign in_word.raw_humidity    = raw_humidity_i;

  // front: input queue
  esc_fifo #(.W($bits(esc_pkg::raw_t)), .DEPTH(IN_DEPTH)) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(in_word), .full_o(full),
    .pop_i(eng_pop), .rdata_o(eng_word), .empty_o(eng_valid_n)
  );

  // back: compensation engine
  esc_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i(!eng_valid_n),
    .in_word_i(eng_word), .in_pop_o(eng_pop), .out_full_i(res_full),
    .out_push_o(res_push), .out_word_o(res_word)
  );

  // result queue
  esc_fifo #(.W($bits(esc_pkg::res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i, .rst_ni, .push_i(res_push), .wdata_i(res_word), .full_o(res_full),
    .pop_i(pop), .rdata_o(head_word), .empty_o(empty)
  );

  assign temperature_o    = head_word.temperature;
  assign pressure_o       = head_word.pressure;
  assign humidity_o       = head_word.humidity;
  assign temp_alarm_o     = head_word.temp_alarm;
  assign humidity_alarm_o = head_word.humidity_alarm;

endmodule

>>> hw/rtl/esc_fifo.sv
// small first-in first-out queue of fixed-width words
// no package dependency
module esc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/esc_mul.sv
// iterative multiplier: low 64 bits of a 64 by 64 product, one 16-bit digit a cycle
// no package dependency
module esc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, b_q, acc_q, part;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;

  // one partial product, shifted into place
  assign part   = (a_q * {48'b0, b_q[{cnt_q, 4'b0} +: 16]}) << {cnt_q, 4'b0};
  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/esc_div.sv
// signed 64-bit divider, truncating quotient and remainder, one bit a cycle
// no package dependency
module esc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o,
  output logic signed [63:0] rem_o
);

  logic [63:0] quo_q, den_q;
  logic [64:0] rem_q, trial;
  logic [5:0]  cnt_q;
  logic        neg_q_q, neg_r_q, busy_q, done_q, fits;

  // restoring step
  assign trial = {rem_q[63:0], quo_q[63]};
  assign fits  = (trial >= {1'b0, den_q});

  assign done_o = done_q;
  assign quo_o  = neg_q_q ? -$signed(quo_q) : $signed(quo_q);
  assign rem_o  = neg_r_q ? -$signed(rem_q[63:0]) : $signed(rem_q[63:0]);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q   <= num_i[63] ? 64'(-num_i) : num_i;
      den_q   <= den_i[63] ? 64'(-den_i) : den_i;
      rem_q   <= '0;
      neg_q_q <= num_i[63] ^ den_i[63];
      neg_r_q <= num_i[63];
    end else if (busy_q) begin
      rem_q <= fits ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[62:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/esc_engine.sv
// compensation engine: sequencer over a shared multiplier and divider
// depends on esc_pkg, esc_mul and esc_div
module esc_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  esc_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  input  esc_pkg::raw_t in_word_i,
  output logic          in_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output esc_pkg::res_t out_word_o
);

  esc_pkg::state_e state_q, state_d;

  logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [63:0] h1, h2, h3, h4, h5, h6;
  logic signed [63:0] ta_q, tb_q, tfine_q, pa_q, sq_q, pb_q, pc_q, dh_q, den_q;
  logic signed [63:0] num_q, q_q, r_q, hv_q, ha_q, hx_q, hy_q, hb_q, hvv_q, hz_q;
  logic [19:0]        adc_p_q;
  logic [15:0]        adc_h_q;
  logic [15:0]        temp_q;
  logic [24:0]        pres_q;
  logic [16:0]        hum_q;
  logic               issued_q, is_mul, is_div, mul_start, div_start;
  logic               mul_done, div_done;
  logic [63:0]        ma, mb, mprod;
  logic signed [63:0] mres, dquo, drem, dbias, t5, ts, px, hy_v, qsum;

  // calibration fields
  assign t1 = {48'b0, cfg_i.temp_coeffs[15:0]};
  assign t2 = esc_pkg::sext16(cfg_i.temp_coeffs[31:16]);
  assign t3 = esc_pkg::sext16(cfg_i.temp_coeffs[47:32]);
  assign p1 = {48'b0, cfg_i.press_low[15:0]};
  assign p2 = esc_pkg::sext16(cfg_i.press_low[31:16]);
  assign p3 = esc_pkg::sext16(cfg_i.press_low[47:32]);
  assign p4 = esc_pkg::sext16(cfg_i.press_low[63:48]);
  assign p5 = esc_pkg::sext16(cfg_i.press_high[15:0]);
  assign p6 = esc_pkg::sext16(cfg_i.press_high[31:16]);
  assign p7 = esc_pkg::sext16(cfg_i.press_high[47:32]);
  assign p8 = esc_pkg::sext16(cfg_i.press_high[63:48]);
  assign p9 = esc_pkg::sext16(cfg_i.press_nine);
  assign h1 = {56'b0, cfg_i.hum_coeffs[7:0]};
  assign h2 = esc_pkg::sext16(cfg_i.hum_coeffs[23:8]);
  assign h3 = {56'b0, cfg_i.hum_coeffs[31:24]};
  assign h4 = esc_pkg::sext12(cfg_i.hum_coeffs[43:32]);
  assign h5 = esc_pkg::sext12(cfg_i.hum_coeffs[55:44]);
  assign h6 = esc_pkg::sext8(cfg_i.hum_coeffs[63:56]);

  esc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb),
    .done_o(mul_done), .prod_o(mprod)
  );

  // second division takes the scaled remainder
  esc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i((state_q == esc_pkg::S_DR) ? r_q : num_q),
    .den_i(den_q), .done_o(div_done), .quo_o(dquo), .rem_o(drem)
  );

  assign mres  = $signed(mprod);
  assign dbias = pc_q + esc_pkg::D_BIAS;
  assign t5    = (tfine_q <<< 2) + tfine_q + 64'sd128;
  assign ts    = t5 >>> 8;
  assign qsum  = q_q + pc_q + pb_q;
  assign px    = (qsum >>> 8) + (p7 <<< 4);
  assign hy_v  = hvv_q - (mres >>> 4);

  // operand selection for the shared multiplier
  always_comb begin
    is_mul = 1'b1;
    ma     = '0;
    mb     = '0;
    case (state_q)
      esc_pkg::S_TA:  begin ma = ta_q;          mb = t2;    end
      esc_pkg::S_TB:  begin ma = tb_q;          mb = tb_q;  end
      esc_pkg::S_TC:  begin ma = tb_q;          mb = t3;    end
      esc_pkg::S_SQ:  begin ma = pa_q;          mb = pa_q;  end
      esc_pkg::S_P6:  begin ma = sq_q;          mb = p6;    end
      esc_pkg::S_P5:  begin ma = pa_q;          mb = p5;    end
      esc_pkg::S_P3:  begin ma = sq_q;          mb = p3;    end
      esc_pkg::S_P2:  begin ma = pa_q;          mb = p2;    end
      esc_pkg::S_P1H: begin ma = dbias >>> 16;  mb = p1;    end
      esc_pkg::S_P1L: begin ma = {48'b0, dbias[15:0]}; mb = p1; end
      esc_pkg::S_R:   begin ma = r_q;           mb = 64'd3125; end
      esc_pkg::S_Q:   begin ma = q_q;           mb = 64'd3125; end
      esc_pkg::S_SS:  begin ma = q_q >>> 13;    mb = q_q >>> 13; end
      esc_pkg::S_P9:  begin ma = sq_q;          mb = p9;    end
      esc_pkg::S_P8:  begin ma = q_q;           mb = p8;    end
      esc_pkg::S_H5:  begin ma = h5;            mb = hv_q;  end
      esc_pkg::S_H6:  begin ma = hv_q;          mb = h6;    end
      esc_pkg::S_H3:  begin ma = hv_q;          mb = h3;    end
      esc_pkg::S_HXY: begin ma = hx_q;          mb = hy_q;  end
      esc_pkg::S_H2:  begin ma = hb_q;          mb = h2;    end
      esc_pkg::S_HAB: begin ma = ha_q;          mb = hb_q;  end
      esc_pkg::S_HS:  begin ma = hvv_q >>> 15;  mb = hvv_q >>> 15; end
      esc_pkg::S_H1:  begin ma = hz_q;          mb = h1;    end
      default:        is_mul = 1'b0;
    endcase
  end

  assign is_div    = (state_q == esc_pkg::S_DQ) || (state_q == esc_pkg::S_DR);
  assign mul_start = is_mul && !issued_q;
  assign div_start = is_div && !issued_q;
  assign in_pop_o  = (state_q == esc_pkg::S_IDLE) && in_valid_i;
  assign out_push_o = (state_q == esc_pkg::S_DONE) && !out_full_i;

  // next step
  always_comb begin
    state_d = state_q;
    case (state_q)
      esc_pkg::S_IDLE: if (in_valid_i) state_d = esc_pkg::S_TA;
      esc_pkg::S_TA:   if (mul_done) state_d = esc_pkg::S_TB;
      esc_pkg::S_TB:   if (mul_done) state_d = esc_pkg::S_TC;
      esc_pkg::S_TC:   if (mul_done) state_d = esc_pkg::S_TEMP;
      esc_pkg::S_TEMP: state_d = esc_pkg::S_SQ;
      esc_pkg::S_SQ:   if (mul_done) state_d = esc_pkg::S_P6;
      esc_pkg::S_P6:   if (mul_done) state_d = esc_pkg::S_P5;
      esc_pkg::S_P5:   if (mul_done) state_d = esc_pkg::S_P3;
      esc_pkg::S_P3:   if (mul_done) state_d = esc_pkg::S_P2;
      esc_pkg::S_P2:   if (mul_done) state_d = esc_pkg::S_P1H;
      esc_pkg::S_P1H:  if (mul_done) state_d = esc_pkg::S_P1L;
      esc_pkg::S_P1L:  if (mul_done) state_d = esc_pkg::S_PCHK;
      esc_pkg::S_PCHK: state_d = (den_q == '0) ? esc_pkg::S_H5 : esc_pkg::S_DQ;
      esc_pkg::S_DQ:   if (div_done) state_d = esc_pkg::S_QCHK;
      esc_pkg::S_QCHK: begin
        if (q_q > esc_pkg::QUOT_GUARD || q_q < -esc_pkg::QUOT_GUARD) begin
          state_d = esc_pkg::S_SS;
        end else begin
          state_d = esc_pkg::S_R;
        end
      end
      esc_pkg::S_R:    if (mul_done) state_d = esc_pkg::S_Q;
      esc_pkg::S_Q:    if (mul_done) state_d = esc_pkg::S_DR;
      esc_pkg::S_DR:   if (div_done) state_d = esc_pkg::S_SS;
      esc_pkg::S_SS:   if (mul_done) state_d = esc_pkg::S_P9;
      esc_pkg::S_P9:   if (mul_done) state_d = esc_pkg::S_P8;
      esc_pkg::S_P8:   if (mul_done) state_d = esc_pkg::S_PRES;
      esc_pkg::S_PRES: state_d = esc_pkg::S_H5;
      esc_pkg::S_H5:   if (mul_done) state_d = esc_pkg::S_H6;
      esc_pkg::S_H6:   if (mul_done) state_d = esc_pkg::S_H3;
      esc_pkg::S_H3:   if (mul_done) state_d = esc_pkg::S_HXY;
      esc_pkg::S_HXY:  if (mul_done) state_d = esc_pkg::S_H2;
      esc_pkg::S_H2:   if (mul_done) state_d = esc_pkg::S_HAB;
      esc_pkg::S_HAB:  if (mul_done) state_d = esc_pkg::S_HCHK;
      esc_pkg::S_HCHK: state_d = (hvv_q <= 64'sd0) ? esc_pkg::S_DONE : esc_pkg::S_HS;
      esc_pkg::S_HS:   if (mul_done) state_d = esc_pkg::S_H1;
      esc_pkg::S_H1:   if (mul_done) state_d = esc_pkg::S_DONE;
      esc_pkg::S_DONE: if (!out_full_i) state_d = esc_pkg::S_IDLE;
      default:         state_d = esc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= esc_pkg::S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) begin
        issued_q <= 1'b1;
      end else if (mul_done || div_done) begin
        issued_q <= 1'b0;
      end
    end
  end

  // datapath write-back per step
  always_ff @(posedge clk_i) begin
    case (state_q)
      esc_pkg::S_IDLE: if (in_valid_i) begin
        adc_p_q <= in_word_i.raw_pressure;
        adc_h_q <= in_word_i.raw_humidity;
        ta_q    <= $signed({47'b0, in_word_i.raw_temperature[19:3]}) - (t1 <<< 1);
        tb_q    <= $signed({48'b0, in_word_i.raw_temperature[19:4]}) - t1;
      end
      esc_pkg::S_TA: if (mul_done) ta_q <= mres >>> 11;
      esc_pkg::S_TB: if (mul_done) tb_q <= mres >>> 12;
      esc_pkg::S_TC: if (mul_done) tfine_q <= ta_q + (mres >>> 14);
      esc_pkg::S_TEMP: begin
        if (ts > 64'sd32767) begin
          temp_q <= 16'h7fff;
        end else if (ts < -64'sd32768) begin
          temp_q <= 16'h8000;
        end else begin
          temp_q <= ts[15:0];
        end
        pa_q <= tfine_q - 64'sd128000;
        hv_q <= tfine_q - 64'sd76800;
      end
      esc_pkg::S_SQ:  if (mul_done) sq_q <= mres;
      esc_pkg::S_P6:  if (mul_done) pb_q <= mres;
      esc_pkg::S_P5:  if (mul_done) pb_q <= pb_q + (mres <<< 17) + (p4 <<< 35);
      esc_pkg::S_P3:  if (mul_done) pc_q <= mres >>> 8;
      esc_pkg::S_P2:  if (mul_done) pc_q <= pc_q + (mres <<< 12);
      esc_pkg::S_P1H: if (mul_done) dh_q <= mres;
      esc_pkg::S_P1L: if (mul_done) den_q <= (dh_q + (mres >>> 16)) >>> 17;
      esc_pkg::S_PCHK: begin
        pres_q <= '0;
        num_q  <= ((64'sd1048576 - $signed({44'b0, adc_p_q})) <<< 31) - pb_q;
      end
      esc_pkg::S_DQ: if (div_done) begin
        q_q <= dquo;
        r_q <= drem;
      end
      esc_pkg::S_QCHK: begin
        if (q_q > esc_pkg::QUOT_GUARD) begin
          q_q <= esc_pkg::QUOT_LIMIT;
        end else if (q_q < -esc_pkg::QUOT_GUARD) begin
          q_q <= -esc_pkg::QUOT_LIMIT;
        end
      end
      esc_pkg::S_R: if (mul_done) r_q <= mres;
      esc_pkg::S_Q: if (mul_done) q_q <= mres;
      esc_pkg::S_DR: if (div_done) begin
        if (q_q + dquo > esc_pkg::QUOT_LIMIT) begin
          q_q <= esc_pkg::QUOT_LIMIT;
        end else if (q_q + dquo < -esc_pkg::QUOT_LIMIT) begin
          q_q <= -esc_pkg::QUOT_LIMIT;
        end else begin
          q_q <= q_q + dquo;
        end
      end
      esc_pkg::S_SS: if (mul_done) sq_q <= mres;
      esc_pkg::S_P9: if (mul_done) pc_q <= mres >>> 25;
      esc_pkg::S_P8: if (mul_done) pb_q <= mres >>> 19;
      esc_pkg::S_PRES: begin
        if (px < 64'sd0) begin
          pres_q <= '0;
        end else if (px > esc_pkg::PRESS_MAX) begin
          pres_q <= esc_pkg::PRESS_MAX[24:0];
        end else begin
          pres_q <= px[24:0];
        end
      end
      esc_pkg::S_H5: if (mul_done) begin
        ha_q <= (($signed({48'b0, adc_h_q}) <<< 14) - (h4 <<< 20) - mres
                 + 64'sd16384) >>> 15;
      end
      esc_pkg::S_H6:  if (mul_done) hx_q <= mres >>> 10;
      esc_pkg::S_H3:  if (mul_done) hy_q <= (mres >>> 11) + 64'sd32768;
      esc_pkg::S_HXY: if (mul_done) hb_q <= (mres >>> 10) + 64'sd2097152;
      esc_pkg::S_H2:  if (mul_done) hb_q <= (mres + 64'sd8192) >>> 14;
      esc_pkg::S_HAB: if (mul_done) hvv_q <= mres;
      esc_pkg::S_HCHK: begin
        hum_q <= '0;
        if (hvv_q > esc_pkg::HV_LIMIT) begin
          hvv_q <= esc_pkg::HV_LIMIT;
        end
      end
      esc_pkg::S_HS: if (mul_done) hz_q <= mres >>> 7;
      esc_pkg::S_H1: if (mul_done) begin
        if (hy_v < 64'sd0) begin
          hum_q <= '0;
        end else if (hy_v > esc_pkg::HUM_MAX) begin
          hum_q <= esc_pkg::HUM_MAX[28:12];
        end else begin
          hum_q <= hy_v[28:12];
        end
      end
      default: ;
    endcase
  end

  // result word with the alarm compares
  always_comb begin
    out_word_o.temperature    = temp_q;
    out_word_o.pressure       = pres_q;
    out_word_o.humidity       = hum_q;
    out_word_o.temp_alarm     = ($signed(temp_q) > $signed(cfg_i.temp_high)) ||
                                ($signed(temp_q) < $signed(cfg_i.temp_low));
    out_word_o.humidity_alarm = (hum_q > cfg_i.hum_high);
  end

endmodule

>>> hw/rtl/esc_checker.sv
// port-level checks of the compensation block, bound to its top level
// depends on env_sensor_compensation's port list
module esc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [15:0] temperature_o,
  input logic [24:0] pressure_o,
  input logic [16:0] humidity_o,
  input logic        temp_alarm_o,
  input logic        humidity_alarm_o
);

  // a waiting word holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(temperature_o) && $stable(pressure_o)
      && $stable(humidity_o) && $stable(temp_alarm_o) && $stable(humidity_alarm_o))
    else $error("result word changed while waiting");

  // humidity never exceeds full scale
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> humidity_o <= 17'd102400)
    else $error("humidity above full scale");

  // zero humidity can never be above a limit
  a_hum_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && humidity_o == 17'd0 |-> !humidity_alarm_o)
    else $error("humidity alarm with zero humidity");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);
